>>> src/taam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package taam_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 256;

  typedef enum logic [3:0] {
    OP_SELECT = 4'd0,
    OP_STORE  = 4'd1,
    OP_LOAD   = 4'd2,
    OP_SAVE   = 4'd3,
    OP_ADD    = 4'd4,
    OP_AADD   = 4'd5,
    OP_SUB    = 4'd6,
    OP_ASUB   = 4'd7,
    OP_MUL    = 4'd8,
    OP_AMUL   = 4'd9,
    OP_DIV    = 4'd10,
    OP_ADIV   = 4'd11,
    OP_POW    = 4'd12,
    OP_APOW   = 4'd13
  } op_t;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_DIV0 = 3'd1,
    ST_ADDR = 3'd2,
    ST_REG  = 3'd3,
    ST_ZNEG = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDWAIT,
    S_DIV,
    S_POW,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> src/two_accumulator_alu_machine_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Ports
// in      | input     | in_valid, in_stall, in_mode[3:0], in_arg[31:0]
// out     | output    | out_valid, out_stall, out_acc_value[31:0], out_selected, out_status[2:0]
//
// One item at a time. Simple ops pass through accumulator memory read, then
// write back and result register. div/pow run on the 32-step iterative unit.
// After reset a clearing pass writes zero to every store word, with in_stall
// high meanwhile. A stalled result holds in the output register; the next
// item is taken once it leaves.
module two_accumulator_alu_machine_top
  import taam_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [3:0]         in_mode,
  input  wire logic [31:0]        in_arg,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_acc_value,
  output logic                    out_selected,
  output logic [2:0]              out_status
);

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  state_t state_r, state_nxt;

  // memories: accumulators (2 words) and word store
  logic [31:0] acc_mem [2];
  logic [31:0] st_mem [STORE_DEPTH];
  logic [31:0] acc_rd_cur_r, acc_rd_op_r, st_rd_r;

  logic        sel_r;
  logic [3:0]  mode_r;
  logic [31:0] arg_r;
  logic [AW:0] clr_r;
  logic        clearing;

  // bookkeeping of an item
  logic        in_fire, out_fire;
  logic        reg_ok, addr_ok, amode;
  logic [31:0] opnd;
  logic        acc_we;
  logic [31:0] acc_wd;
  logic        st_we;
  logic [AW-1:0] st_addr;
  status_t     stat;
  logic        unit_start, unit_done;
  logic [31:0] unit_res;
  logic        res_load;

  assign clearing = (clr_r < STORE_DEPTH[AW:0]);
  assign in_stall = clearing || (state_r != S_IDLE) || out_valid;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  assign reg_ok  = (arg_r == 32'd1) || (arg_r == 32'd2);
  assign addr_ok = (arg_r < STORE_DEPTH);
  assign amode   = mode_r[0] && (mode_r >= 4'd5) && (mode_r <= 4'd13);
  assign opnd    = amode ? acc_rd_op_r : arg_r;
  assign st_addr = clearing ? clr_r[AW-1:0] : (in_fire ? in_arg[AW-1:0] : arg_r[AW-1:0]);

  // state machine, flags, write-back selection
  always_comb begin
    state_nxt  = state_r;
    acc_we     = 1'b0;
    acc_wd     = 32'd0;
    st_we      = 1'b0;
    stat       = ST_OK;
    unit_start = 1'b0;
    res_load   = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_RDWAIT;
      S_RDWAIT: begin
        if (amode && !reg_ok) begin
          stat = ST_REG;
          res_load = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DONE;
          res_load  = 1'b1;
          case (mode_r)
            OP_SELECT: if (!reg_ok) stat = ST_REG;
            OP_STORE: begin
              acc_we = 1'b1; acc_wd = arg_r;
            end
            OP_LOAD: begin
              if (!addr_ok) stat = ST_ADDR;
              else begin
                acc_we = 1'b1; acc_wd = st_rd_r;
              end
            end
            OP_SAVE: begin
              if (!addr_ok) stat = ST_ADDR;
              else st_we = 1'b1;
            end
            OP_ADD, OP_AADD: begin
              acc_we = 1'b1; acc_wd = acc_rd_cur_r + opnd;
            end
            OP_SUB, OP_ASUB: begin
              acc_we = 1'b1; acc_wd = acc_rd_cur_r - opnd;
            end
            OP_MUL, OP_AMUL: begin
              acc_we = 1'b1; acc_wd = acc_rd_cur_r * opnd;
            end
            OP_DIV, OP_ADIV: begin
              if (opnd == 32'd0) stat = ST_DIV0;
              else begin
                unit_start = 1'b1; res_load = 1'b0; state_nxt = S_DIV;
              end
            end
            OP_POW, OP_APOW: begin
              if (opnd[31]) begin
                if (acc_rd_cur_r == 32'd0) stat = ST_ZNEG;
                else begin
                  acc_we = 1'b1;
                  if (acc_rd_cur_r == 32'd1) acc_wd = 32'd1;
                  else if (acc_rd_cur_r == 32'hFFFF_FFFF)
                    acc_wd = opnd[0] ? 32'hFFFF_FFFF : 32'd1;
                  else acc_wd = 32'd0;
                end
              end else begin
                unit_start = 1'b1; res_load = 1'b0; state_nxt = S_POW;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV, S_POW: begin
        if (unit_done) begin
          acc_we = 1'b1; acc_wd = unit_res;
          res_load = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_mode;
      arg_r  <= in_arg;
    end
  end

  // accumulator memory: two operand read ports, one write port; the result register also reads it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_mem[0] <= 32'd0;
      acc_mem[1] <= 32'd0;
    end else if (acc_we) begin
      acc_mem[sel_r] <= acc_wd;
    end
  end
  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc_rd_cur_r <= acc_mem[sel_r];
      acc_rd_op_r  <= acc_mem[in_arg[0] ? 1'b0 : 1'b1];
    end
  end

  // word store with clearing pass
  always_ff @(posedge clk) begin
    if (clearing) st_mem[st_addr] <= 32'd0;
    else if (st_we) st_mem[st_addr] <= acc_rd_cur_r;
    st_rd_r <= st_mem[st_addr];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (clearing) clr_r <= clr_r + 1'b1;
  end

  // selection pointer
  always_ff @(posedge clk) begin
    if (!rst_n) sel_r <= 1'b0;
    else if (state_r == S_RDWAIT && mode_r == OP_SELECT && reg_ok)
      sel_r <= ~arg_r[0];
  end

  taam_mulit u_mulit (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (unit_start),
    .is_pow (state_nxt == S_POW),
    .op_a   (acc_rd_cur_r),
    .op_b   (opnd),
    .done   (unit_done),
    .res    (unit_res)
  );

  // result register: value read back from memory in S_DONE
  logic stat_pend_r;
  logic [2:0] stat_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid   <= 1'b0;
      stat_pend_r <= 1'b0;
    end else begin
      stat_pend_r <= res_load;
      if (stat_pend_r) out_valid <= 1'b1;
      else if (out_fire) out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (res_load) stat_r <= stat;
    if (stat_pend_r) begin
      out_acc_value <= acc_mem[sel_r];
      out_selected  <= sel_r;
      out_status    <= stat_r;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
    else $error("item taken while result pending");
  assert property (@(posedge clk) disable iff (!rst_n) acc_we |-> !st_we)
    else $error("both stores written");
  assert property (@(posedge clk) disable iff (!rst_n) clearing |-> state_r == S_IDLE)
    else $error("item during clearing pass");

endmodule
`default_nettype wire

>>> src/taam_mulit.sv
`timescale 1ns / 1ps
`default_nettype none
// Iterative divide / power unit. Division: radix-2 restoring on magnitudes,
// one quotient bit per cycle. Power: right-to-left square and
// multiply, one exponent bit per cycle, products registered.
module taam_mulit
  import taam_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        is_pow,
  input  wire logic [31:0] op_a,
  input  wire logic [31:0] op_b,
  output logic             done,
  output logic [31:0]      res
);

  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        pow_r;
  logic        neg_r;
  logic [31:0] rem_r, quo_r, dvs_r;
  logic [31:0] pr_r, pb_r, pe_r;
  logic [32:0] trial;
  logic [31:0] rem_sh;
  logic [31:0] mag_a, mag_b;

  assign mag_a = op_a[31] ? (32'd0 - op_a) : op_a;
  assign mag_b = op_b[31] ? (32'd0 - op_b) : op_b;

  // one restoring step
  assign rem_sh = {rem_r[30:0], quo_r[31]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 6'd0;
      done   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done   <= busy_r && (cnt_r == 6'd31);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      pow_r <= is_pow;
      neg_r <= op_a[31] ^ op_b[31];
      rem_r <= 32'd0;
      quo_r <= mag_a;
      dvs_r <= mag_b;
      pr_r  <= 32'd1;
      pb_r  <= op_a;
      pe_r  <= op_b;
    end else if (busy_r) begin
      if (!pow_r) begin
        if (!trial[32]) begin
          rem_r <= trial[31:0];
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[30:0], 1'b0};
        end
      end else begin
        if (pe_r[0]) pr_r <= pr_r * pb_r;
        pb_r <= pb_r * pb_r;
        pe_r <= {1'b0, pe_r[31:1]};
      end
    end
  end

  assign res = pow_r ? pr_r : (neg_r ? (32'd0 - quo_r) : quo_r);

  assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy_r)
    else $error("done while busy");
  assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_r)
    else $error("start did not launch");
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> cnt_r <= 6'd31)
    else $error("step count overrun");

endmodule
`default_nettype wire
